/* rtl/tun_pkg.sv */
package tun_pkg;

  localparam int COORD_W = 16;
  localparam int NORM_W  = 16;
  localparam int EDGE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = CROSS_W - 1;
  localparam int SUM_W   = 2 * MAG_W;
  localparam int LANES   = 3;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic signed [COORD_W-1:0] third_x;
    logic signed [COORD_W-1:0] third_y;
    logic signed [COORD_W-1:0] third_z;
  } tun_in_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     degenerate;
  } tun_out_t;

endpackage

/* rtl/tun_root_step.sv */
module tun_root_step #(
  parameter int K  = 0,
  parameter int AW = 100,
  parameter int BW = 85,
  parameter int RW = 98,
  parameter int QW = 15
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [tun_pkg::SUM_W-1:0] s_i,
  input  logic [RW-1:0]        r_i,
  input  logic [AW-1:0]        a_i,
  input  logic signed [BW-1:0] b_i,
  input  logic [QW-1:0]        q_i,
  output logic [RW-1:0]        r_o,
  output logic [AW-1:0]        a_o,
  output logic signed [BW-1:0] b_o,
  output logic [QW-1:0]        q_o
);
  import tun_pkg::*;

  localparam int CW = AW + 2;

  logic signed [CW-1:0] a_s, b_s, s_s, r_s, cand;
  logic                 take;
  logic [AW-1:0]        a_d;
  logic signed [BW-1:0] b_d;
  logic [QW-1:0]        q_d;

  always_comb begin
    a_s  = signed'(CW'(a_i));
    b_s  = CW'(b_i);
    s_s  = signed'(CW'(s_i));
    r_s  = signed'(CW'(r_i));
    cand = a_s + (b_s <<< (K + 2)) + (s_s <<< (2 * K + 2));
    take = (cand <= r_s);
    a_d  = take ? AW'(cand) : a_i;
    b_d  = take ? (b_i + (signed'(BW'(s_i)) <<< (K + 1))) : b_i;
    q_d  = take ? (q_i | (QW'(1) << K)) : q_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o <= r_i;
      a_o <= a_d;
      b_o <= b_d;
      q_o <= q_d;
    end
  end

endmodule

/* rtl/triangle_unit_normal.sv */
// Unit face normal of a triangle.
// Input channel: in_valid_i / in_stall_o carry one word of three vertices,
// nine signed 16-bit coordinates. Output channel: out_valid_o / out_stall_i
// carry one word per input: the normal in signed fixed point with
// NORMAL_FRAC_BITS fraction bits and a degenerate flag; a zero cross
// product gives a zero normal with the flag set.
// Throughput: one word per cycle while the receiver does not stall. Stages in
// order: edges, products, cross product, squares, sum, one restoring
// square-root-divide step per result bit, then the output register.
// Every stage has its own valid bit; a stage loads whenever it is empty
// or the stage after it moves, so bubbles close up under a stall.
// When the receiver stalls, the output word holds; the pipe keeps
// accepting words until every stage is full, then in_stall_o rises.
// Reset clears all valid bits; the data registers have no reset.
module triangle_unit_normal #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tun_pkg::tun_in_t in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tun_pkg::tun_out_t out_word_o
);
  import tun_pkg::*;

  localparam int F     = NORMAL_FRAC_BITS;
  localparam int NSTEP = F + 1;
  localparam int SB    = 5;
  localparam int NST   = SB + NSTEP + 1;
  localparam int AW    = SUM_W + 2 * F + 4;
  localparam int BW    = SUM_W + F + 3;
  localparam int RW    = SUM_W + 2 * F + 2;
  localparam int QW    = F + 1;

  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = ~out_stall_i;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end

  assign in_stall_o = ~rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  logic signed [EDGE_W-1:0]  ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic signed [PROD_W-1:0]  p_q [6];
  logic [MAG_W-1:0]          mag_q [LANES];
  logic [LANES-1:0]          sgn_q [NST];
  logic                      deg_q [NST];
  logic [SUM_W-1:0]          sq_q [LANES];
  logic [SUM_W-1:0]          s_q [NSTEP+1];
  logic [RW-1:0]             r0_q [LANES];
  logic [RW-1:0]             r_q [LANES][NSTEP+1];
  logic [AW-1:0]             a_q [LANES][NSTEP+1];
  logic signed [BW-1:0]      b_q [LANES][NSTEP+1];
  logic [QW-1:0]             q_q [LANES][NSTEP+1];
  logic signed [CROSS_W-1:0] c_d [LANES];
  tun_out_t                  out_q;

  function automatic logic signed [EDGE_W-1:0] sub_e(logic signed [COORD_W-1:0] p,
                                                     logic signed [COORD_W-1:0] r);
    return EDGE_W'(p) - EDGE_W'(r);
  endfunction

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ax_q <= sub_e(in_word_i.first_x, in_word_i.second_x);
      ay_q <= sub_e(in_word_i.first_y, in_word_i.second_y);
      az_q <= sub_e(in_word_i.first_z, in_word_i.second_z);
      bx_q <= sub_e(in_word_i.first_x, in_word_i.third_x);
      by_q <= sub_e(in_word_i.first_y, in_word_i.third_y);
      bz_q <= sub_e(in_word_i.first_z, in_word_i.third_z);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      p_q[0] <= ay_q * bz_q;
      p_q[1] <= by_q * az_q;
      p_q[2] <= bx_q * az_q;
      p_q[3] <= ax_q * bz_q;
      p_q[4] <= ax_q * by_q;
      p_q[5] <= bx_q * ay_q;
    end
  end

  always_comb begin
    for (int ln = 0; ln < LANES; ln++) begin
      c_d[ln] = CROSS_W'(p_q[2*ln]) - CROSS_W'(p_q[2*ln+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int ln = 0; ln < LANES; ln++) begin
        mag_q[ln] <= MAG_W'(c_d[ln][CROSS_W-1] ? -c_d[ln] : c_d[ln]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      for (int ln = 0; ln < LANES; ln++) begin
        sq_q[ln] <= SUM_W'(mag_q[ln]) * SUM_W'(mag_q[ln]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      for (int ln = 0; ln < LANES; ln++) begin
        r0_q[ln] <= RW'(sq_q[ln]) << (2 * F + 2);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int ln = 0; ln < LANES; ln++) begin
        sgn_q[2][ln] <= c_d[ln][CROSS_W-1];
      end
      deg_q[2] <= (c_d[0] == '0) && (c_d[1] == '0) && (c_d[2] == '0);
    end
    for (int k = 3; k < NST - 1; k++) begin
      if (rdy[k]) begin
        sgn_q[k] <= sgn_q[k-1];
        deg_q[k] <= deg_q[k-1];
      end
    end
  end

  for (genvar ln = 0; ln < LANES; ln++) begin : g_lane
    assign r_q[ln][0] = r0_q[ln];
    assign a_q[ln][0] = AW'(s_q[0]);
    assign b_q[ln][0] = -signed'(BW'(s_q[0]));
    assign q_q[ln][0] = '0;
    for (genvar j = 0; j < NSTEP; j++) begin : g_step
      tun_root_step #(
        .K (F - j),
        .AW(AW),
        .BW(BW),
        .RW(RW),
        .QW(QW)
      ) u_step (
        .clk_i(clk_i),
        .en_i (rdy[SB+j]),
        .s_i  (s_q[j]),
        .r_i  (r_q[ln][j]),
        .a_i  (a_q[ln][j]),
        .b_i  (b_q[ln][j]),
        .q_i  (q_q[ln][j]),
        .r_o  (r_q[ln][j+1]),
        .a_o  (a_q[ln][j+1]),
        .b_o  (b_q[ln][j+1]),
        .q_o  (q_q[ln][j+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s_q[0] <= sq_q[0] + sq_q[1] + sq_q[2];
    end
    for (int j = 0; j < NSTEP; j++) begin
      if (rdy[SB+j]) begin
        s_q[j+1] <= s_q[j];
      end
    end
  end

  function automatic logic signed [NORM_W-1:0] signed_q(logic [QW-1:0] q, logic neg,
                                                        logic deg);
    logic signed [QW:0] sq;
    sq = signed'({1'b0, q});
    if (deg) begin
      return '0;
    end
    return neg ? NORM_W'(-sq) : NORM_W'(sq);
  endfunction

  always_ff @(posedge clk_i) begin
    if (rdy[NST-1]) begin
      out_q.normal_x   <= signed_q(q_q[0][NSTEP], sgn_q[NST-2][0], deg_q[NST-2]);
      out_q.normal_y   <= signed_q(q_q[1][NSTEP], sgn_q[NST-2][1], deg_q[NST-2]);
      out_q.normal_z   <= signed_q(q_q[2][NSTEP], sgn_q[NST-2][2], deg_q[NST-2]);
      out_q.degenerate <= deg_q[NST-2];
    end
  end

  assign out_valid_o = v_q[NST-1];
  assign out_word_o  = out_q;

endmodule

/* rtl/tun_checker.sv */
module tun_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input tun_pkg::tun_in_t  in_word_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input tun_pkg::tun_out_t out_word_o
);
  import tun_pkg::*;

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.degenerate |->
      out_word_o.normal_x == '0 && out_word_o.normal_y == '0 && out_word_o.normal_z == '0)
    else $error("degenerate word with nonzero normal");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_moving_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_word_i  (in_word_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);

/* verif/triangle_unit_normal_tb.sv */
module triangle_unit_normal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tun_pkg::*;

  localparam int FRAC_BITS = 14;
  localparam int HOLD_CYCLES = 300;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  tun_in_t  in_word_i;
  logic     out_valid_o;
  logic     out_stall_i;
  tun_out_t out_word_o;

  tun_in_t  tri_pending_q[$];
  tun_out_t normal_q[$];
  int       idle_pct;
  int       stall_pct;
  int       fail_cnt;
  int       hold_left;
  logic     hold_go;

  triangle_unit_normal #(.NORMAL_FRAC_BITS(FRAC_BITS)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic logic [15:0] unit_component(longint c, logic [127:0] sum);
    logic [127:0] mag;
    logic [127:0] rhs;
    logic [127:0] d;
    int lo;
    int hi;
    int mid;
    logic [15:0] q;
    mag = (c < 0) ? 128'(-c) : 128'(c);
    rhs = (mag * mag) << (2 * FRAC_BITS + 2);
    lo = 0;
    hi = 1 << FRAC_BITS;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      d = 128'(2 * mid - 1);
      if (d * d * sum <= rhs) lo = mid;
      else hi = mid - 1;
    end
    q = 16'(lo);
    return (c < 0) ? -q : q;
  endfunction

  function automatic tun_out_t unit_normal(tun_in_t w);
    longint ax, ay, az, bx, by, bz, cx, cy, cz;
    logic [127:0] sum;
    tun_out_t r;
    ax = longint'(w.first_x) - longint'(w.second_x);
    ay = longint'(w.first_y) - longint'(w.second_y);
    az = longint'(w.first_z) - longint'(w.second_z);
    bx = longint'(w.first_x) - longint'(w.third_x);
    by = longint'(w.first_y) - longint'(w.third_y);
    bz = longint'(w.first_z) - longint'(w.third_z);
    cx = ay * bz - by * az;
    cy = bx * az - ax * bz;
    cz = ax * by - bx * ay;
    r = '0;
    if (cx == 0 && cy == 0 && cz == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    sum = (cx < 0 ? 128'(-cx) : 128'(cx)) * (cx < 0 ? 128'(-cx) : 128'(cx))
        + (cy < 0 ? 128'(-cy) : 128'(cy)) * (cy < 0 ? 128'(-cy) : 128'(cy))
        + (cz < 0 ? 128'(-cz) : 128'(cz)) * (cz < 0 ? 128'(-cz) : 128'(cz));
    r.normal_x = unit_component(cx, sum);
    r.normal_y = unit_component(cy, sum);
    r.normal_z = unit_component(cz, sum);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_cnt++;
  endtask

  function automatic tun_in_t make_tri(int x1, int y1, int z1, int x2, int y2, int z2,
                                       int x3, int y3, int z3);
    tun_in_t w;
    w.first_x  = 16'(x1);
    w.first_y  = 16'(y1);
    w.first_z  = 16'(z1);
    w.second_x = 16'(x2);
    w.second_y = 16'(y2);
    w.second_z = 16'(z2);
    w.third_x  = 16'(x3);
    w.third_y  = 16'(y3);
    w.third_z  = 16'(z3);
    return w;
  endfunction

  function automatic int rnd_coord(int kind);
    case (kind)
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 64) - 32;
      2: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: return $urandom_range(0, 2048) - 1024;
    endcase
  endfunction

  function automatic tun_in_t rnd_tri();
    int kind;
    int x1, y1, z1, dx, dy, dz, k;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      x1 = rnd_coord(3);
      y1 = rnd_coord(3);
      z1 = rnd_coord(3);
      dx = rnd_coord(1);
      dy = rnd_coord(1);
      dz = rnd_coord(1);
      k  = $urandom_range(0, 6) - 3;
      return make_tri(x1, y1, z1, x1 + dx, y1 + dy, z1 + dz,
                      x1 + k * dx, y1 + k * dy, z1 + k * dz);
    end
    kind = (kind < 5) ? 0 : kind - 5;
    return make_tri(rnd_coord(kind), rnd_coord(kind), rnd_coord(kind),
                    rnd_coord(kind), rnd_coord(kind), rnd_coord(kind),
                    rnd_coord(kind), rnd_coord(kind), rnd_coord(kind));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) normal_q.push_back(unit_normal(in_word_i));
      if (!in_valid_i || !in_stall_o) begin
        if (tri_pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_word_i  <= tri_pending_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= (hold_left > 1) || ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    tun_out_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (normal_q.size() == 0) begin
        report_mismatch("output word with none expected");
      end else begin
        exp_w = normal_q.pop_front();
        if (out_word_o.normal_x !== exp_w.normal_x)
          report_mismatch($sformatf("normal_x got %0d exp %0d",
                                    out_word_o.normal_x, exp_w.normal_x));
        if (out_word_o.normal_y !== exp_w.normal_y)
          report_mismatch($sformatf("normal_y got %0d exp %0d",
                                    out_word_o.normal_y, exp_w.normal_y));
        if (out_word_o.normal_z !== exp_w.normal_z)
          report_mismatch($sformatf("normal_z got %0d exp %0d",
                                    out_word_o.normal_z, exp_w.normal_z));
        if (out_word_o.degenerate !== exp_w.degenerate)
          report_mismatch($sformatf("degenerate got %0b exp %0b",
                                    out_word_o.degenerate, exp_w.degenerate));
      end
    end
  end

  task automatic drain();
    while (tri_pending_q.size() > 0 || in_valid_i || normal_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int phase;
    rst_ni    <= 1'b0;
    hold_go   <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    fail_cnt  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    tri_pending_q.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    tri_pending_q.push_back(make_tri(5, 6, 7, 5, 6, 7, 1, 2, 3));
    tri_pending_q.push_back(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));
    tri_pending_q.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    tri_pending_q.push_back(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0));
    tri_pending_q.push_back(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
    tri_pending_q.push_back(make_tri(0, 0, 0, 0, 0, 1, 0, 1, 0));
    tri_pending_q.push_back(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
    tri_pending_q.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1));
    tri_pending_q.push_back(make_tri(32767, 32767, 32767, -32768, -32768, 32767,
                                     -32768, 32767, -32768));
    tri_pending_q.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                                     -32768, 32767, -32768));
    tri_pending_q.push_back(make_tri(32767, -32768, 0, -32768, 32767, 0,
                                     32767, 32767, 32767));
    tri_pending_q.push_back(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                                     -32768, -32768, 32767));
    tri_pending_q.push_back(make_tri(32767, 32767, 32767, 32767, 32767, 32767,
                                     32767, 32767, 32767));
    tri_pending_q.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                     -32768, -32768, -32768));
    tri_pending_q.push_back(make_tri(0, 0, 0, 3, 4, 0, 0, 0, 5));
    tri_pending_q.push_back(make_tri(1, 2, 3, -4, 5, -6, 7, -8, 9));
    tri_pending_q.push_back(make_tri(0, 0, 0, 1, 1, 0, 0, 1, 1));
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      repeat (433) tri_pending_q.push_back(rnd_tri());
      if (phase == 0) begin
        @(posedge clk_i);
        hold_go <= 1'b1;
        @(posedge clk_i);
        hold_go <= 1'b0;
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0 && normal_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* triangle_unit_normal.f */
rtl/tun_pkg.sv
rtl/tun_root_step.sv
rtl/triangle_unit_normal.sv
rtl/tun_checker.sv
verif/triangle_unit_normal_tb.sv
